>>> rtl/tmrs_pkg.sv
// Shared constants and types of the tiny register machine step block.
`timescale 1ns / 1ps
`default_nettype none

package tmrs_pkg;

   // Register file: 2**REG_IDX_W words, indexed by the low bits of an argument
   localparam int REG_IDX_W  = 5;
   localparam int REG_COUNT  = 1 << REG_IDX_W;
   // Data memory: 2**MEM_ADDR_W words, addressed by the low bits of a register
   localparam int MEM_ADDR_W = 10;
   localparam int MEM_WORDS  = 1 << MEM_ADDR_W;

   localparam int DATA_W     = 32;
   localparam int ARG_W      = 8;
   localparam int OP_W       = 8;
   localparam int PUT_W      = 2 * ARG_W;

   typedef enum logic [OP_W-1:0] {
      OP_PRINT = 8'd0,
      OP_PUT   = 8'd1,
      OP_ADD   = 8'd2,
      OP_STORE = 8'd3,
      OP_LOAD  = 8'd4,
      OP_MUL   = 8'd5
   } opcode_type;

   typedef logic [REG_IDX_W-1:0]  reg_idx_type;
   typedef logic [MEM_ADDR_W-1:0] mem_addr_type;
   typedef logic [DATA_W-1:0]     word_type;

endpackage

`default_nettype wire

>>> rtl/tmrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tmrs_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 32,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Read returns the contents before a write at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/tiny_register_machine_step.sv
// Top level of the tiny register machine step block.
`timescale 1ns / 1ps
`default_nettype none

// Executes one instruction per transfer on the req_ channel through a three-stage
// pipeline: the register file is read in the accept cycle, operands arrive
// in the cycle after (with forwarding from the two writes still in flight),
// where add, multiply, store and the data memory read for a load happen;
// the register write-back follows in stage 2. After the clearing sweep a new
// instruction can be accepted every cycle while no print is held off, so the
// sustained rate is then one instruction per cycle. A print (opcode 0) gives
// its result on rsp_ via s1_valid_ff and the output register; it is held off
// while that register is full and not being taken, or while the previous print
// is still one stage short of it. Other opcodes never wait on the rsp_ side.
// After reset the block zeroes data memory and register file with req_ready low.

module tiny_register_machine_step (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_opcode,
   input  wire logic [7:0]  req_first_arg,
   input  wire logic [7:0]  req_second_arg,
   input  wire logic [7:0]  req_third_arg,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_printed_value
);

   // Clearing sweep
   logic                   clear_ff;
   tmrs_pkg::mem_addr_type clr_cnt_ff;

   // Stage 1: operands come out of the register file copies
   logic                   s1_valid_ff, s1_valid_in;
   tmrs_pkg::opcode_type   s1_op_ff, s1_op_in;
   tmrs_pkg::reg_idx_type  s1_dst_ff;
   tmrs_pkg::reg_idx_type  s1_ra0_ff, s1_ra1_ff;
   logic [tmrs_pkg::PUT_W-1:0] s1_put_ff;

   // Stage 2: register write-back
   logic                   s2_wr_ff, s2_wr_in;
   logic                   s2_load_ff;
   tmrs_pkg::reg_idx_type  s2_dst_ff;
   tmrs_pkg::word_type     s2_val_ff, s2_val_in;

   // Write committed at the last edge, not yet visible in the RAM read data
   logic                   prev_wr_ff;
   tmrs_pkg::reg_idx_type  prev_addr_ff;
   tmrs_pkg::word_type     prev_data_ff;

   // Output register
   logic                   rsp_valid_ff;
   tmrs_pkg::word_type     rsp_data_ff;

   logic                   accept;
   logic                   s1_print;
   tmrs_pkg::reg_idx_type  arg_a, arg_b, arg_c;
   tmrs_pkg::reg_idx_type  rd0_addr, rd1_addr;
   tmrs_pkg::word_type     rf0_rdata, rf1_rdata, dm_rdata;
   tmrs_pkg::word_type     op0, op1;
   logic [2*tmrs_pkg::DATA_W-1:0] mul_full;
   logic                   rf_we;
   tmrs_pkg::reg_idx_type  rf_waddr;
   tmrs_pkg::word_type     rf_wdata, wb_data;
   logic                   dm_we;
   tmrs_pkg::mem_addr_type dm_waddr;
   tmrs_pkg::word_type     dm_wdata;

   // Accept: a print waits until the output register is sure to be free
   assign s1_print  = s1_valid_ff && (s1_op_ff == tmrs_pkg::OP_PRINT);
   assign req_ready = !clear_ff &&
                      ((req_opcode != tmrs_pkg::OP_PRINT) ||
                       ((!rsp_valid_ff || rsp_ready) && !s1_print));
   assign accept    = req_valid && req_ready;

   assign arg_a = req_first_arg[tmrs_pkg::REG_IDX_W-1:0];
   assign arg_b = req_second_arg[tmrs_pkg::REG_IDX_W-1:0];
   assign arg_c = req_third_arg[tmrs_pkg::REG_IDX_W-1:0];

   // Decode and register read addresses
   // port 0: print -> r0, store -> data reg, else first operand / address reg
   // port 1: store -> address reg, else second operand
   always_comb begin
      s1_valid_in = 1'b0;
      s1_op_in    = tmrs_pkg::OP_PRINT;
      rd0_addr    = arg_b;
      rd1_addr    = arg_c;
      case (req_opcode)
         tmrs_pkg::OP_PRINT: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_PRINT;
            rd0_addr    = '0;
         end
         tmrs_pkg::OP_PUT: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_PUT;
         end
         tmrs_pkg::OP_ADD: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_ADD;
         end
         tmrs_pkg::OP_STORE: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_STORE;
            rd0_addr    = arg_a;
            rd1_addr    = arg_b;
         end
         tmrs_pkg::OP_LOAD: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_LOAD;
         end
         tmrs_pkg::OP_MUL: begin
            s1_valid_in = accept;
            s1_op_in    = tmrs_pkg::OP_MUL;
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
   end

   // Register file, two copies written alike, one read port each
   tmrs_ram #(.WIDTH(tmrs_pkg::DATA_W), .DEPTH(tmrs_pkg::REG_COUNT)) u_rf0 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rd0_addr),
      .rd_data (rf0_rdata)
   );

   tmrs_ram #(.WIDTH(tmrs_pkg::DATA_W), .DEPTH(tmrs_pkg::REG_COUNT)) u_rf1 (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (rd1_addr),
      .rd_data (rf1_rdata)
   );

   // Stage 2 write-back value; a load takes the data memory output
   assign wb_data = s2_load_ff ? dm_rdata : s2_val_ff;

   // Operand forwarding: write-back in progress first, then last edge's write
   always_comb begin
      op0 = rf0_rdata;
      if (s2_wr_ff && (s2_dst_ff == s1_ra0_ff)) begin
         op0 = wb_data;
      end else if (prev_wr_ff && (prev_addr_ff == s1_ra0_ff)) begin
         op0 = prev_data_ff;
      end
   end

   always_comb begin
      op1 = rf1_rdata;
      if (s2_wr_ff && (s2_dst_ff == s1_ra1_ff)) begin
         op1 = wb_data;
      end else if (prev_wr_ff && (prev_addr_ff == s1_ra1_ff)) begin
         op1 = prev_data_ff;
      end
   end

   assign mul_full = op0 * op1;

   // Stage 1 execute
   always_comb begin
      s2_wr_in  = 1'b0;
      s2_val_in = {{(tmrs_pkg::DATA_W - tmrs_pkg::PUT_W){1'b0}}, s1_put_ff};
      case (s1_op_ff)
         tmrs_pkg::OP_PUT: begin
            s2_wr_in = s1_valid_ff;
         end
         tmrs_pkg::OP_ADD: begin
            s2_wr_in  = s1_valid_ff;
            s2_val_in = op0 + op1;
         end
         tmrs_pkg::OP_MUL: begin
            s2_wr_in  = s1_valid_ff;
            s2_val_in = mul_full[tmrs_pkg::DATA_W-1:0];
         end
         tmrs_pkg::OP_LOAD: begin
            s2_wr_in = s1_valid_ff;
         end
         default: begin
            s2_wr_in = 1'b0;
         end
      endcase
   end

   // Data memory: clearing sweep or a store from stage 1
   always_comb begin
      if (clear_ff) begin
         dm_we    = 1'b1;
         dm_waddr = clr_cnt_ff;
         dm_wdata = '0;
      end else begin
         dm_we    = s1_valid_ff && (s1_op_ff == tmrs_pkg::OP_STORE);
         dm_waddr = op1[tmrs_pkg::MEM_ADDR_W-1:0];
         dm_wdata = op0;
      end
   end

   tmrs_ram #(.WIDTH(tmrs_pkg::DATA_W), .DEPTH(tmrs_pkg::MEM_WORDS)) u_dm (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_addr (op0[tmrs_pkg::MEM_ADDR_W-1:0]),
      .rd_data (dm_rdata)
   );

   // Register file write port: clearing sweep or stage 2 write-back
   always_comb begin
      if (clear_ff) begin
         rf_we    = 1'b1;
         rf_waddr = clr_cnt_ff[tmrs_pkg::REG_IDX_W-1:0];
         rf_wdata = '0;
      end else begin
         rf_we    = s2_wr_ff;
         rf_waddr = s2_dst_ff;
         rf_wdata = wb_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         s2_wr_ff     <= 1'b0;
         prev_wr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == tmrs_pkg::MEM_ADDR_W'(tmrs_pkg::MEM_WORDS - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         s1_valid_ff <= s1_valid_in;
         s2_wr_ff    <= s2_wr_in;
         prev_wr_ff  <= rf_we;
         if (s1_print) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff  <= s1_op_in;
         s1_dst_ff <= arg_a;
         s1_ra0_ff <= rd0_addr;
         s1_ra1_ff <= rd1_addr;
         s1_put_ff <= {req_second_arg, req_third_arg};
      end
      s2_load_ff   <= (s1_op_ff == tmrs_pkg::OP_LOAD);
      s2_dst_ff    <= s1_dst_ff;
      s2_val_ff    <= s2_val_in;
      prev_addr_ff <= rf_waddr;
      prev_data_ff <= rf_wdata;
      if (s1_print) begin
         rsp_data_ff <= op0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_printed_value = rsp_data_ff;

   // A print reaching stage 1 always finds the output register empty
   a_print_slot_free: assert property (@(posedge clock) disable iff (reset)
      s1_print |-> !rsp_valid_ff)
      else $error("print overruns output register");

   // No instruction enters while the clearing sweep runs
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !accept)
      else $error("transfer accepted during clearing sweep");

   // Pipeline is empty while clearing owns the write ports
   a_clear_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!s1_valid_ff && !s2_wr_ff))
      else $error("pipeline active during clearing sweep");

   // A new result only appears in the cycle after a print in stage 1
   a_rsp_from_print: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_print))
      else $error("result without print");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the tiny register machine: directed table, then random programs.
`timescale 1ns / 1ps

module testbench;
   import tmrs_pkg::*;

   localparam int DIRECTED_ROWS  = 26;
   localparam int TOTAL_ITEMS    = 1250;
   localparam int MAX_REPORTS    = 10;
   // no-transfer cycles; covers the clear after reset several times over
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 12;

   // opcodes outside the defined set: the block must ignore them
   localparam logic [OP_W-1:0] OP_UNUSED_LOW  = 8'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HIGH = 8'd255;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [ARG_W-1:0] first_arg;
      logic [ARG_W-1:0] second_arg;
      logic [ARG_W-1:0] third_arg;
      logic             has_known;   // print row with a hand-written result
      word_type         known_value;
   } instr_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [ARG_W-1:0]    req_first_arg = '0;
   logic [ARG_W-1:0]    req_second_arg = '0;
   logic [ARG_W-1:0]    req_third_arg = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [31:0]  rsp_printed_value;

   // predictor state
   word_type  machine_regs [REG_COUNT];
   word_type  machine_mem [MEM_WORDS];

   instr_type directed_tab [DIRECTED_ROWS];
   instr_type program_q [$];
   word_type  printed_expect_q [$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;

   tiny_register_machine_step dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_first_arg     (req_first_arg),
      .req_second_arg    (req_second_arg),
      .req_third_arg     (req_third_arg),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_printed_value (rsp_printed_value)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one instruction to the predictor state; a print yields register 0.
   task automatic execute_instruction(input instr_type ins, output bit prints,
                                      output word_type value);
      reg_idx_type  dst;
      reg_idx_type  src_b;
      reg_idx_type  src_c;
      mem_addr_type addr;
      dst   = ins.first_arg[REG_IDX_W-1:0];
      src_b = ins.second_arg[REG_IDX_W-1:0];
      src_c = ins.third_arg[REG_IDX_W-1:0];
      addr  = machine_regs[src_b][MEM_ADDR_W-1:0];
      prints = 1'b0;
      value  = '0;
      case (ins.opcode)
         OP_PRINT: begin
            prints = 1'b1;
            value  = machine_regs[0];
         end
         OP_PUT:   machine_regs[dst] = word_type'({ins.second_arg, ins.third_arg});
         OP_ADD:   machine_regs[dst] = machine_regs[src_b] + machine_regs[src_c];
         OP_MUL:   machine_regs[dst] = machine_regs[src_b] * machine_regs[src_c];
         OP_STORE: machine_mem[addr] = machine_regs[dst];
         OP_LOAD:  machine_regs[dst] = machine_mem[addr];
         default: ;
      endcase
   endtask

   // Register argument: random upper bits, index biased toward a few registers.
   function automatic logic [ARG_W-1:0] reg_arg(input bit favor_zero);
      logic [ARG_W-REG_IDX_W-1:0] upper;
      reg_idx_type                idx;
      upper = (ARG_W - REG_IDX_W)'($urandom_range(0, (1 << (ARG_W - REG_IDX_W)) - 1));
      if (favor_zero && $urandom_range(0, 9) < 4)
         idx = '0;
      else if ($urandom_range(0, 9) < 6)
         idx = REG_IDX_W'($urandom_range(0, 3));
      else
         idx = REG_IDX_W'($urandom_range(0, REG_COUNT - 1));
      return {upper, idx};
   endfunction

   // One random instruction of a program that keeps feeding register 0.
   function automatic instr_type random_instruction();
      instr_type ins;
      int        pick;
      ins = '0;
      pick = $urandom_range(0, 99);
      ins.first_arg  = reg_arg(1'b1);
      ins.second_arg = reg_arg(1'b0);
      ins.third_arg  = reg_arg(1'b0);
      if (pick < 18) begin
         ins.opcode = OP_PRINT;
         ins.first_arg  = ARG_W'($urandom_range(0, 255));
         ins.second_arg = ARG_W'($urandom_range(0, 255));
         ins.third_arg  = ARG_W'($urandom_range(0, 255));
      end else if (pick < 38) begin
         ins.opcode = OP_PUT;
         if ($urandom_range(0, 9) < 4) begin
            // value whose address lands in a few low words
            ins.second_arg = ARG_W'($urandom_range(0, 255) & 8'hFC);
            ins.third_arg  = ARG_W'($urandom_range(0, 7));
         end else begin
            ins.second_arg = ARG_W'($urandom_range(0, 255));
            ins.third_arg  = ARG_W'($urandom_range(0, 255));
         end
      end else if (pick < 53) begin
         ins.opcode = OP_ADD;
      end else if (pick < 63) begin
         ins.opcode = OP_MUL;
      end else if (pick < 75) begin
         ins.opcode = OP_STORE;
         ins.third_arg = ARG_W'($urandom_range(0, 255));
      end else if (pick < 88) begin
         ins.opcode = OP_LOAD;
         ins.third_arg = ARG_W'($urandom_range(0, 255));
      end else begin
         ins.opcode = OP_W'($urandom_range(OP_UNUSED_LOW, OP_UNUSED_HIGH));
      end
      return ins;
   endfunction

   // Build the whole instruction stream: directed rows first, then random programs.
   initial begin : build_program
      instr_type ins;
      for (int i = 0; i < REG_COUNT; i++) machine_regs[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) machine_mem[i] = '0;

      //                opcode          a1     a2     a3     known  value
      directed_tab[0]  = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_0000};
      directed_tab[1]  = '{OP_PUT,       8'h00, 8'hFF, 8'hFF, 1'b0, 32'h0};
      directed_tab[2]  = '{OP_PRINT,     8'hFF, 8'hFF, 8'hFF, 1'b1, 32'h0000_FFFF};
      // index uses low bits only: 0xE1 is register 1
      directed_tab[3]  = '{OP_PUT,       8'hE1, 8'h00, 8'h01, 1'b0, 32'h0};
      directed_tab[4]  = '{OP_ADD,       8'h80, 8'h20, 8'h41, 1'b0, 32'h0};
      directed_tab[5]  = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'h0001_0000};
      directed_tab[6]  = '{OP_PUT,       8'h02, 8'hFF, 8'hFF, 1'b0, 32'h0};
      directed_tab[7]  = '{OP_MUL,       8'h03, 8'h02, 8'h02, 1'b0, 32'h0};
      // add overflow wraps at 32 bits
      directed_tab[8]  = '{OP_ADD,       8'h00, 8'h03, 8'h03, 1'b0, 32'h0};
      directed_tab[9]  = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'hFFFC_0002};
      // multiply overflow
      directed_tab[10] = '{OP_MUL,       8'h00, 8'h03, 8'h23, 1'b0, 32'h0};
      directed_tab[11] = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b0, 32'h0};
      // address 0x400 wraps to word 0
      directed_tab[12] = '{OP_PUT,       8'hFF, 8'h04, 8'h00, 1'b0, 32'h0};
      directed_tab[13] = '{OP_STORE,     8'h03, 8'hFF, 8'hAA, 1'b0, 32'h0};
      directed_tab[14] = '{OP_PUT,       8'h1E, 8'h00, 8'h00, 1'b0, 32'h0};
      directed_tab[15] = '{OP_LOAD,      8'h00, 8'h1E, 8'h55, 1'b0, 32'h0};
      directed_tab[16] = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'hFFFE_0001};
      // top word, reached directly and through wrap of 0xFFFF
      directed_tab[17] = '{OP_PUT,       8'h1D, 8'h03, 8'hFF, 1'b0, 32'h0};
      directed_tab[18] = '{OP_STORE,     8'h02, 8'h1D, 8'h00, 1'b0, 32'h0};
      directed_tab[19] = '{OP_PUT,       8'h1C, 8'hFF, 8'hFF, 1'b0, 32'h0};
      directed_tab[20] = '{OP_LOAD,      8'h00, 8'h1C, 8'h00, 1'b0, 32'h0};
      // unknown opcodes leave register 0 alone
      directed_tab[21] = '{OP_UNUSED_LOW,  8'h00, 8'h00, 8'h00, 1'b0, 32'h0};
      directed_tab[22] = '{OP_UNUSED_HIGH, 8'hFF, 8'hFF, 8'hFF, 1'b0, 32'h0};
      directed_tab[23] = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_FFFF};
      // memory word 1 was cleared at reset
      directed_tab[24] = '{OP_LOAD,      8'h00, 8'h01, 8'h00, 1'b0, 32'h0};
      directed_tab[25] = '{OP_PRINT,     8'h00, 8'h00, 8'h00, 1'b1, 32'h0000_0000};

      for (int i = 0; i < DIRECTED_ROWS; i++) program_q.push_back(directed_tab[i]);

      while (program_q.size() < TOTAL_ITEMS) begin
         ins = random_instruction();
         program_q.push_back(ins);
      end
   end

   // Sender, receiver and result check, all at the rising edge.
   always @(posedge clock) begin : bench_step
      bit        progress;
      bit        prints;
      word_type  value;
      word_type  want;
      instr_type current;
      int        accepted;
      int        burst_left;
      int        gap_left;
      int        run_left;
      int        stall_left;
      bit        drain_hold;
      if (reset) begin
         req_valid   <= 1'b0;
         rsp_ready   <= 1'b0;
         idle_cycles <= 0;
         accepted    = 0;
         burst_left  = 0;
         gap_left    = 0;
         run_left    = 0;
         stall_left  = 0;
         drain_hold  = 1'b0;
      end else begin
         progress = 1'b0;

         // result transfer: compare with the oldest expected print
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            if (printed_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected print result %h", rsp_printed_value);
            end else begin
               want = printed_expect_q.pop_front();
               if (rsp_printed_value !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("printed_value mismatch: expected %h, got %h",
                              want, rsp_printed_value);
               end
            end
         end

         // instruction transfer: advance the predictor
         if (req_valid && req_ready) begin
            progress = 1'b1;
            current = program_q.pop_front();
            execute_instruction(current, prints, value);
            if (prints)
               printed_expect_q.push_back(current.has_known ? current.known_value : value);
            accepted++;
            // let the pipeline drain once between directed and random parts
            if (accepted == DIRECTED_ROWS) drain_hold = 1'b1;
         end

         // next instruction: bursts with gaps, occasional drain pause
         if (!req_valid || req_ready) begin
            if (drain_hold && printed_expect_q.size() == 0) drain_hold = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (drain_hold || program_q.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_opcode     <= program_q[0].opcode;
               req_first_arg  <= program_q[0].first_arg;
               req_second_arg <= program_q[0].second_arg;
               req_third_arg  <= program_q[0].third_arg;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) == 0) begin
                  // long stretch with no gaps
                  burst_left = $urandom_range(100, 200);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(0, 23);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                  if ($urandom_range(0, 39) == 0) drain_hold = 1'b1;
               end
            end
         end

         // receiver: ready runs and stalls of random length
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_ready <= 1'b1;
         end else begin
            run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 15);
            stall_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
            rsp_ready <= 1'b1;
         end

         idle_cycles <= progress ? 0 : idle_cycles + 1;
      end
   end

   // End of run: all instructions sent, all prints back, then a short tail.
   initial begin : run_end
      wait (!reset);
      while (program_q.size() != 0 || req_valid || printed_expect_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog: too long without any transfer
   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("Regression FAIL");
      $finish;
   end

endmodule
